FILE: rtl/core/bsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

	// widths of the root datapath
	localparam int SUM_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int REM_W     = ROOT_W + 1;
	localparam int NUM_CELLS = ROOT_W;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

	// what one root cell hands to the next
	typedef struct packed {
		logic [SUM_W-1:0]  rad;    // radicand bits still to be consumed, top first
		logic [REM_W-1:0]  rem;    // partial remainder
		logic [ROOT_W-1:0] root;   // partial root
		logic signed [31:0] inner; // inside part, travels alongside
	} cell_data_t;

endpackage

`default_nettype wire

FILE: rtl/core/bsd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [30:0]        half_x;
	logic [30:0]        half_y;
	logic [30:0]        half_z;

	modport source (
		output valid, point_x, point_y, point_z, half_x, half_y, half_z,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, half_x, half_y, half_z,
		output ready
	);
endinterface

interface bsd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] signed_distance;

	modport source (
		output valid, signed_distance,
		input  ready
	);
	modport sink (
		input  valid, signed_distance,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/box_signed_distance.sv
`timescale 1ns / 1ps
`default_nettype none

// signed distance from a point to an origin-centred box, fixed point throughout.
// each transaction on point carries one point and the box half-extents and gives
// exactly one transaction on distance. one point is taken every clock cycle while
// distance is not stalled; there are four front stages (per-axis saturated difference,
// squares, two adds), then a row of 32 root cells, each working out one bit of the
// truncated 64-bit square root, then the output register that adds the inside part
// and saturates. every stage has its own valid bit and a stalled stage only holds
// the stages behind it, so bubbles are squeezed out and new points keep entering
// while a finished result waits on distance, until every stage holds a point.

module box_signed_distance (
	input  wire logic clk,
	input  wire logic arst_n,
	bsd_in_if.sink    point,
	bsd_out_if.source distance
);
	import bsd_pkg::*;

	// cell chain links, index 0 from the front end, NUM_CELLS into the output stage
	logic       c_valid [NUM_CELLS+1];
	logic       c_ready [NUM_CELLS+1];
	cell_data_t c_data  [NUM_CELLS+1];

	// distances, squares and sum of squares
	bsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.point    (point),
		.dn_valid (c_valid[0]),
		.dn_ready (c_ready[0]),
		.dn_data  (c_data[0])
	);

	// square root, one result bit per cell
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		bsd_root_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (c_valid[k]),
			.up_ready (c_ready[k]),
			.up_data  (c_data[k]),
			.dn_valid (c_valid[k+1]),
			.dn_ready (c_ready[k+1]),
			.dn_data  (c_data[k+1])
		);
	end

	// outside plus inside part, saturated, registered onto distance
	bsd_tail u_tail (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (c_valid[NUM_CELLS]),
		.up_ready (c_ready[NUM_CELLS]),
		.up_data  (c_data[NUM_CELLS]),
		.distance (distance)
	);

endmodule

`default_nettype wire

FILE: rtl/core/bsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bsd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bsd_in_if.sink             point,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output bsd_pkg::cell_data_t dn_data
);
	import bsd_pkg::*;

	// saturated |p| - h
	function automatic logic signed [31:0] axis_diff(logic signed [31:0] p, logic [30:0] h);
		logic [32:0]        mag;
		logic signed [33:0] diff;
		mag  = p[31] ? (33'd0 - {1'b1, p}) : {1'b0, p};
		diff = $signed({1'b0, mag}) - $signed({3'b000, h});
		if (diff > $signed({2'b00, S32_MAX})) begin
			return S32_MAX;
		end
		return diff[31:0];
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic signed [31:0] d_s1 [3];
	logic [61:0]        sq_s2 [3];
	logic signed [31:0] inner_s2, inner_s3, inner_s4;
	logic [62:0]        sq01_s3;
	logic [61:0]        sq2_s3;
	logic [SUM_W-1:0]   sum_s4;

	logic [30:0]        pos [3];
	logic signed [31:0] dmax;

	assign rdy_s4 = !vld_s4 || dn_ready;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign point.ready = rdy_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos[i] = (d_s1[i] > 32'sd0) ? d_s1[i][30:0] : 31'd0;
		end
		dmax = d_s1[0];
		if (d_s1[1] > dmax) begin
			dmax = d_s1[1];
		end
		if (d_s1[2] > dmax) begin
			dmax = d_s1[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= point.valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (rdy_s1 && point.valid) begin
			d_s1[0] <= axis_diff(point.point_x, point.half_x);
			d_s1[1] <= axis_diff(point.point_y, point.half_y);
			d_s1[2] <= axis_diff(point.point_z, point.half_z);
		end
		if (rdy_s2 && vld_s1) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= pos[i] * pos[i];
			end
			inner_s2 <= (dmax > 32'sd0) ? 32'sd0 : dmax;
		end
		if (rdy_s3 && vld_s2) begin
			sq01_s3  <= {1'b0, sq_s2[0]} + {1'b0, sq_s2[1]};
			sq2_s3   <= sq_s2[2];
			inner_s3 <= inner_s2;
		end
		if (rdy_s4 && vld_s3) begin
			sum_s4   <= {1'b0, sq01_s3} + {2'b00, sq2_s3};
			inner_s4 <= inner_s3;
		end
	end

	assign dn_valid      = vld_s4;
	assign dn_data.rad   = sum_s4;
	assign dn_data.rem   = '0;
	assign dn_data.root  = '0;
	assign dn_data.inner = inner_s4;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.ready |=> vld_s1)
		else $error("accepted point did not enter the first stage");

	a_inside_no_outside: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && inner_s3 != 32'sd0 |-> sq01_s3 == '0 && sq2_s3 == '0)
		else $error("inside part and outside part both non-zero");

endmodule

`default_nettype wire

FILE: rtl/core/bsd_root_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bsd_root_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                up_valid,
	output logic                     up_ready,
	input  wire bsd_pkg::cell_data_t up_data,
	output logic                     dn_valid,
	input  wire logic                dn_ready,
	output bsd_pkg::cell_data_t      dn_data
);
	import bsd_pkg::*;

	logic               vld_q;
	cell_data_t         data_q;
	logic [REM_W+1:0]   cur;
	logic [REM_W+1:0]   trial;
	logic [REM_W+1:0]   diff;
	logic               ge;

	// one restoring step: two radicand bits in, one root bit out
	assign cur   = {up_data.rem, up_data.rad[SUM_W-1 -: 2]};
	assign trial = {1'b0, up_data.root, 2'b01};
	assign ge    = cur >= trial;
	assign diff  = cur - trial;

	assign up_ready = !vld_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q.rad   <= {up_data.rad[SUM_W-3:0], 2'b00};
			data_q.rem   <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
			data_q.root  <= {up_data.root[ROOT_W-2:0], ge};
			data_q.inner <= up_data.inner;
		end
	end

	assign dn_valid = vld_q;
	assign dn_data  = data_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> {1'b0, data_q.rem} <= {data_q.root, 1'b0, 1'b0} >> 1)
		else $error("partial remainder exceeds twice the partial root");

endmodule

`default_nettype wire

FILE: rtl/core/bsd_tail.sv
`timescale 1ns / 1ps
`default_nettype none

module bsd_tail (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                up_valid,
	output logic                     up_ready,
	input  wire bsd_pkg::cell_data_t up_data,
	bsd_out_if.source                distance
);
	import bsd_pkg::*;

	logic               vld_q;
	logic signed [31:0] dist_q;
	logic signed [33:0] total;

	assign total = $signed({2'b00, up_data.root})
		+ $signed({{2{up_data.inner[31]}}, up_data.inner});

	assign up_ready = !vld_q || distance.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			dist_q <= (total > $signed({2'b00, S32_MAX})) ? S32_MAX : total[31:0];
		end
	end

	assign distance.valid           = vld_q;
	assign distance.signed_distance = dist_q;

	a_root_excludes_inner: assert property (@(posedge clk) disable iff (!arst_n)
		up_valid && up_data.root != '0 |-> up_data.inner == 32'sd0)
		else $error("non-zero root arrived with a negative inside part");

endmodule

`default_nettype wire
